[sv/stfe_pkg.sv]
// ----------------------------------------------------------------------------
// stfe_pkg
// Shared constants, types and the sine table builder for the tone generator.
// ----------------------------------------------------------------------------
package stfe_pkg;

   localparam int PHASE_W        = 32;
   localparam int CSR_DATA_W     = 32;
   localparam int SAMPLE_W       = 15;
   localparam int ROM_MAG_W      = 14;
   localparam int COUNT_MAX_W    = 22;
   localparam int AMP            = 16000;

   localparam int TABLE_DEPTH    = 1024;
   localparam int TABLE_IDX_W    = $clog2(TABLE_DEPTH);

   localparam int FADE_LEN_DEF   = 882;
   localparam int COUNT_BITS_DEF = 22;

   localparam logic [PHASE_W-1:0]     RESET_PHASE_STEP   = 32'd42852281;
   localparam logic [COUNT_MAX_W-1:0] RESET_SAMPLE_COUNT = 22'd8820;

   localparam logic CSR_PHASE_STEP   = 1'b0;
   localparam logic CSR_SAMPLE_COUNT = 1'b1;

   typedef struct packed {
      logic                   run;
      logic                   last;
      logic [TABLE_IDX_W-1:0] ti;
   } front_type;

   typedef logic signed [SAMPLE_W-1:0] rom_type [TABLE_DEPTH];

   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
   localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;
   localparam logic [63:0] LOW32_MASK  = 64'hFFFFFFFF;
   localparam logic [63:0] LOW30_MASK  = 64'h3FFFFFFF;

   localparam logic [63:0] SIN_DIV [14] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
      64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
   };
   localparam logic [63:0] COS_DIV [14] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
      64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
   };

   // floor(a*b / 2^60) in Q60
   function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [63:0] ah, al, bh, bl, mid, lo, t;
      ah  = a >> 32;
      al  = a & LOW32_MASK;
      bh  = b >> 32;
      bl  = b & LOW32_MASK;
      mid = ah * bl + al * bh;
      lo  = al * bl;
      t   = (lo >> 32) + (mid & LOW32_MASK);
      return ah * bh * 64'd16 + (mid >> 32) * 64'd16 + (t >> 28);
   endfunction

   function automatic logic [63:0] series_q60(logic [63:0] x, logic odd);
      logic [63:0] x2, term, sum;
      x2   = mul_q60(x, x);
      term = odd ? x : ONE_Q60;
      sum  = term;
      for (int n = 1; n <= 14; n++) begin
         if (odd) begin
            term = mul_q60(term, x2) / SIN_DIV[n-1];
         end else begin
            term = mul_q60(term, x2) / COS_DIV[n-1];
         end
         if ((n % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rom_entry(int k);
      logic [63:0] k4, q, rem, x, s, mag;
      k4  = 64'(k) * 64'd4;
      q   = k4 / TABLE_DEPTH;
      rem = k4 % TABLE_DEPTH;
      x   = (HALF_PI_Q60 / TABLE_DEPTH) * rem
          + ((HALF_PI_Q60 % TABLE_DEPTH) * rem) / TABLE_DEPTH;
      s   = series_q60(x, (q[0] == 1'b0));
      if (s > ONE_Q60) begin
         s = ONE_Q60;
      end
      mag = ((s >> 30) * 64'(AMP) + (((s & LOW30_MASK) * 64'(AMP)) >> 30)) >> 30;
      return (q >= 64'd2) ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
   endfunction

   function automatic rom_type sine_table();
      rom_type t;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         t[k] = rom_entry(k);
      end
      return t;
   endfunction

endpackage

[sv/sine_tone_with_fade_envelope.sv]
// Pipeline: a result passes through the table read, ramp multiply and
// reciprocal multiply stages in that order, each stage one register.
// Throughput: one input transfer per cycle unless every stage is full and
// stalled; stages advance independently, so empty stages keep filling.
// Reset clears the phase, index, run flag and pipeline valids and loads
// the register defaults; the sine table is a constant ROM.
// ----------------------------------------------------------------------------
// sine_tone_with_fade_envelope
// Table-based sine tone generator with linear fade in and fade out.
// ----------------------------------------------------------------------------
module sine_tone_with_fade_envelope
   import stfe_pkg::*;
#(
   parameter int FADE_LEN   = FADE_LEN_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_sample_valid,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CntW  = (COUNT_BITS < COUNT_MAX_W) ? COUNT_BITS : COUNT_MAX_W;
   localparam int RampW = $clog2(FADE_LEN + 1);

   logic [PHASE_W-1:0] phase_step_ff;
   logic [CntW-1:0]    sample_count_ff;
   logic               env_ready, accept;
   front_type          front;
   logic [RampW-1:0]   ramp;

   assign csr_ready = 1'b1;
   assign req_stall = !env_ready;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= RESET_PHASE_STEP;
         sample_count_ff <= CntW'(RESET_SAMPLE_COUNT);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP: begin
               phase_step_ff <= csr_wdata[PHASE_W-1:0];
            end
            CSR_SAMPLE_COUNT: begin
               sample_count_ff <= csr_wdata[CntW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   stfe_seq #(
      .FADE_LEN   (FADE_LEN),
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .restart      (req_restart),
      .phase_step   (phase_step_ff),
      .sample_count (sample_count_ff),
      .front        (front),
      .ramp         (ramp)
   );

   stfe_env #(
      .FADE_LEN (FADE_LEN)
   ) u_env (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (env_ready),
      .front            (front),
      .ramp             (ramp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_last         (rsp_last)
   );

endmodule

[sv/stfe_seq.sv]
// ----------------------------------------------------------------------------
// stfe_seq
// Tone sequencer: phase accumulator, sample index, run flag, fade ramp and
// sine table index for the item being transferred.
// ----------------------------------------------------------------------------
module stfe_seq
   import stfe_pkg::*;
#(
   parameter int FADE_LEN   = FADE_LEN_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int CntW  = (COUNT_BITS < COUNT_MAX_W) ? COUNT_BITS : COUNT_MAX_W,
   localparam int RampW = $clog2(FADE_LEN + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               restart,
   input  logic [PHASE_W-1:0] phase_step,
   input  logic [CntW-1:0]    sample_count,
   output front_type          front,
   output logic [RampW-1:0]   ramp
);

   localparam int CmpW = ((CntW > RampW) ? CntW : RampW) + 1;
   localparam int TiPW = PHASE_W + TABLE_IDX_W;

   logic [PHASE_W-1:0] phase_ff, phase_in, phase_eff;
   logic [CntW-1:0]    index_ff, index_in, idx_eff;
   logic               running_ff, running_in;
   logic               run, last;
   logic [CmpW-1:0]    idx_x, cnt_x, fade_x, ramp_x;
   logic [TiPW-1:0]    ti_prod;

   always_comb begin
      idx_eff   = restart ? '0 : index_ff;
      phase_eff = restart ? '0 : phase_ff;
      run       = restart ? (sample_count != '0) : running_ff;
      if (idx_eff >= sample_count) begin
         run = 1'b0;
      end
      last = run && (idx_eff == (sample_count - CntW'(1)));

      idx_x  = CmpW'(idx_eff);
      cnt_x  = CmpW'(sample_count);
      fade_x = CmpW'(FADE_LEN);
      if ((idx_x + fade_x) > cnt_x) begin
         ramp_x = cnt_x - idx_x;
      end else if (idx_x < fade_x) begin
         ramp_x = idx_x;
      end else begin
         ramp_x = fade_x;
      end
      ramp = run ? RampW'(ramp_x) : '0;

      ti_prod = TiPW'(phase_eff) * TiPW'(TABLE_DEPTH);

      phase_in   = run ? (phase_eff + phase_step) : phase_eff;
      index_in   = run ? (idx_eff + CntW'(1)) : idx_eff;
      running_in = run && !last;

      front.run  = run;
      front.last = last;
      front.ti   = ti_prod[TiPW-1:PHASE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         index_ff   <= '0;
         running_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         running_ff <= running_in;
      end
   end

   a_zero_len_idle: assert property (@(posedge clock) disable iff (reset)
      accept && restart && (sample_count == '0) |=> !running_ff)
      else $error("zero-length restart left the tone running");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      accept && front.last |=> !running_ff)
      else $error("tone still running after its final sample");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !front.run && !restart |=> $stable(index_ff))
      else $error("sample index moved on an idle transfer");

endmodule

[sv/stfe_env.sv]
// ----------------------------------------------------------------------------
// stfe_env
// Envelope pipeline: registered sine table read, magnitude times ramp, then
// division by the fade length through an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module stfe_env
   import stfe_pkg::*;
#(
   parameter int FADE_LEN = FADE_LEN_DEF,
   localparam int RampW = $clog2(FADE_LEN + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  front_type                  front,
   input  logic [RampW-1:0]           ramp,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_sample_valid,
   output logic                       rsp_last
);

   localparam int MagW    = ROM_MAG_W + RampW;
   localparam int FadeLog = $clog2(FADE_LEN);
   localparam int Shift   = MagW + FadeLog;
   localparam int RecipW  = MagW + 1;
   localparam int ProdW   = MagW + RecipW;
   localparam logic [RecipW-1:0] RECIP =
      RecipW'(((64'd1 << Shift) + 64'(FADE_LEN) - 64'd1) / 64'(FADE_LEN));
   localparam rom_type SINE_ROM = sine_table();

   logic                       s1_valid_ff, s1_run_ff, s1_last_ff;
   logic signed [SAMPLE_W-1:0] s1_rom_ff;
   logic [RampW-1:0]           s1_ramp_ff;

   logic                       s2_valid_ff, s2_run_ff, s2_last_ff, s2_neg_ff;
   logic [MagW-1:0]            s2_mag_ff, s2_mag_in;

   logic                       out_valid_ff, out_run_ff, out_last_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;

   logic                       rdy1, rdy2, rdy3;
   logic [ROM_MAG_W-1:0]       rom_abs;
   logic [ProdW-1:0]           quot_prod;
   logic signed [SAMPLE_W-1:0] quot;

   assign rdy3     = !out_valid_ff || !rsp_stall;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      rom_abs   = ROM_MAG_W'(s1_rom_ff[SAMPLE_W-1] ? -s1_rom_ff : s1_rom_ff);
      s2_mag_in = MagW'(rom_abs) * MagW'(s1_ramp_ff);

      quot_prod     = ProdW'(s2_mag_ff) * ProdW'(RECIP);
      quot          = SAMPLE_W'(quot_prod >> Shift);
      out_sample_in = s2_neg_ff ? -quot : quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= in_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_rom_ff  <= SINE_ROM[front.ti];
         s1_ramp_ff <= ramp;
         s1_run_ff  <= front.run;
         s1_last_ff <= front.last;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_mag_ff  <= s2_mag_in;
         s2_neg_ff  <= s1_rom_ff[SAMPLE_W-1];
         s2_run_ff  <= s1_run_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (rdy3 && s2_valid_ff) begin
         out_sample_ff <= out_sample_in;
         out_run_ff    <= s2_run_ff;
         out_last_ff   <= s2_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sample       = out_sample_ff;
   assign rsp_sample_valid = out_run_ff;
   assign rsp_last         = out_last_ff;

   a_last_in_tone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_sample_valid)
      else $error("final-sample flag outside a running tone");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_valid |-> (rsp_sample == '0))
      else $error("nonzero sample while no tone runs");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_mag_ff <= MagW'(AMP * FADE_LEN)))
      else $error("enveloped magnitude out of range");

endmodule

[dv/tone_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_checker
// Watches the tick, sample and register channels of the tone generator.
// Keeps its own copy of the phase, index, run flag and registers, builds
// the sine table in Q60 fixed point at time zero, works out the sample due
// for every accepted tick and compares each delivered sample against the
// oldest one due. Mismatches and the number of samples still due are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module tone_checker
   import stfe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_restart,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       rsp_sample_valid,
   input  logic                       rsp_last,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   output int                         mismatch_count,
   output int                         samples_due
);

   localparam logic [63:0] Q60_ONE     = 64'h1000000000000000;
   localparam logic [63:0] Q60_HALF_PI = 64'h1921FB54442D1846;
   localparam int          TONE_AMP    = 16000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sample_valid;
      logic                       last;
   } tone_out_type;

   int           sine_rom [TABLE_DEPTH];
   logic [31:0]  step_reg;
   int unsigned  len_reg;
   logic [31:0]  phase_acc;
   int unsigned  sample_idx;
   logic         playing;
   tone_out_type due_samples [$];
   int           errors = 0;

   function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[123:60];
   endfunction

   function automatic logic [63:0] taylor_q60(logic [63:0] x, bit want_sin);
      logic [63:0] x_sq, term, acc, div;
      x_sq = q60_product(x, x);
      term = want_sin ? x : Q60_ONE;
      acc  = term;
      for (int n = 1; n <= 14; n++) begin
         div  = want_sin ? 64'(2 * n * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
         term = q60_product(term, x_sq) / div;
         acc  = ((n % 2) == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   function automatic int sine_entry(int k);
      logic [127:0] angle, scaled;
      logic [63:0]  s;
      int           quad, pos, mag;
      quad   = (4 * k) / TABLE_DEPTH;
      pos    = (4 * k) % TABLE_DEPTH;
      angle  = ({64'd0, Q60_HALF_PI} * 128'(pos)) / TABLE_DEPTH;
      s      = taylor_q60(angle[63:0], (quad % 2) == 0);
      if (s > Q60_ONE) begin
         s = Q60_ONE;
      end
      scaled = {64'd0, s} * 128'(TONE_AMP);
      mag    = int'(scaled >> 60);
      return (quad >= 2) ? -mag : mag;
   endfunction

   function automatic tone_out_type next_tone_sample(logic restart);
      tone_out_type r;
      longint       pos, len, ramp;
      r = '0;
      if (restart) begin
         phase_acc  = '0;
         sample_idx = 0;
         playing    = (len_reg != 0);
      end
      if (playing && sample_idx >= len_reg) begin
         playing = 1'b0;
      end
      if (playing) begin
         pos  = longint'(sample_idx);
         len  = longint'(len_reg);
         ramp = longint'(FADE_LEN_DEF);
         if (pos < FADE_LEN_DEF) begin
            ramp = pos;
         end
         if (pos > len - FADE_LEN_DEF) begin
            ramp = len - pos;
         end
         r.sample = SAMPLE_W'((longint'(sine_rom[phase_acc[31 -: TABLE_IDX_W]]) * ramp)
                              / FADE_LEN_DEF);
         r.sample_valid = 1'b1;
         r.last         = (pos == len - 1);
         phase_acc      = phase_acc + step_reg;
         sample_idx     = sample_idx + 1;
         if (r.last) begin
            playing = 1'b0;
         end
      end
      return r;
   endfunction

   initial begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         sine_rom[k] = sine_entry(k);
      end
   end

   always @(posedge clock) begin : watch
      tone_out_type want, got;
      if (reset) begin
         step_reg   = RESET_PHASE_STEP;
         len_reg    = 32'(RESET_SAMPLE_COUNT);
         phase_acc  = '0;
         sample_idx = 0;
         playing    = 1'b0;
         due_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PHASE_STEP) begin
               step_reg = csr_wdata;
            end else begin
               len_reg = 32'(csr_wdata[COUNT_BITS_DEF-1:0]);
            end
         end
         if (req_valid && !req_stall) begin
            due_samples.push_back(next_tone_sample(req_restart));
         end
         if (rsp_valid && !rsp_stall) begin
            got.sample       = rsp_sample;
            got.sample_valid = rsp_sample_valid;
            got.last         = rsp_last;
            if (due_samples.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("ERROR: sample transfer with none due: %s%0d valid=%b last=%b",
                           "sample=", got.sample, got.sample_valid, got.last);
               end
            end else begin
               want = due_samples.pop_front();
               if (got.sample !== want.sample || got.sample_valid !== want.sample_valid
                   || got.last !== want.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("ERROR: sample mismatch: expected sample=%0d valid=%b last=%b,",
                              want.sample, want.sample_valid, want.last);
                     $display("       got sample=%0d valid=%b last=%b",
                              got.sample, got.sample_valid, got.last);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      samples_due    <= due_samples.size();
   end

endmodule

[dv/tb_sine_tone_with_fade_envelope.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_tone_with_fade_envelope
// Drives ticks and register writes into the tone generator: a directed
// pass over the corner cases, then random tones of mixed lengths and steps
// under random sender and receiver idling or a held receiver stall. A checker
// beside the block predicts and compares every sample; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sine_tone_with_fade_envelope;
   import stfe_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 80;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_sample_valid;
   logic                       rsp_last;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic                       csr_index   = CSR_PHASE_STEP;
   logic [CSR_DATA_W-1:0]      csr_wdata   = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int squeeze_reqs  = 0;
   int quiet_cycles  = 0;
   int fail_count;
   int outstanding;

   always #10 clock = ~clock;

   sine_tone_with_fade_envelope u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   tone_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (fail_count),
      .samples_due      (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("sine_tone_with_fade_envelope verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : sample_sink
      int seen, hold;
      seen = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (squeeze_reqs != seen) begin
            seen = squeeze_reqs;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic tick(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // drain, let the pipeline empty, then write both registers
   task automatic program_tone(input logic [31:0] step, input logic [31:0] len);
      drain();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= step;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int          sent, run, sel;
      logic [31:0] step, len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      tick(1'b0);
      tick(1'b1);
      repeat (3) tick(1'b0);

      program_tone(32'hFFFF_FFFF, 32'd3);
      tick(1'b1);
      repeat (3) tick(1'b0);

      program_tone(32'h0000_0000, 32'd0);
      tick(1'b1);
      tick(1'b0);

      program_tone(32'h8000_0000, 32'h003F_FFFF);
      tick(1'b1);
      repeat (2) tick(1'b0);
      tick(1'b1);
      tick(1'b0);

      program_tone(32'h8000_0000, 32'd1);
      tick(1'b0);
      tick(1'b1);

      program_tone(32'h0040_0000, 32'hFFC0_0372);
      tick(1'b1);
      repeat (4) tick(1'b0);

      for (int ph = 0; ph < 3; ph++) begin
         drain();
         case (ph)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct <= 88;
            end
            1: begin
               send_idle_pct = 88;
               recv_idle_pct <= 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               squeeze_reqs  <= squeeze_reqs + 1;
            end
         endcase
         sent = 0;
         while (sent < 195) begin
            if ($urandom_range(2) == 0) begin
               sel = $urandom_range(7);
               case (sel)
                  0:       step = 32'h0000_0000;
                  1:       step = 32'hFFFF_FFFF;
                  2:       step = 32'h8000_0000;
                  default: step = $urandom;
               endcase
               sel = $urandom_range(9);
               case (sel)
                  0:       len = 32'd0;
                  6, 7:    len = $urandom_range(900, 41);
                  8:       len = ($urandom_range(1) == 0) ? 32'h003F_FFFF : $urandom_range(22'h3FFFFF);
                  9:       len = $urandom;
                  default: len = $urandom_range(40, 1);
               endcase
               program_tone(step, len);
               tick($urandom_range(4) != 0);
            end else begin
               tick(1'b1);
            end
            sent++;
            run = $urandom_range(50, 1);
            for (int i = 0; i < run; i++) begin
               tick($urandom_range(24) == 0);
               sent++;
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("sine_tone_with_fade_envelope verification clean");
      end else begin
         $display("sine_tone_with_fade_envelope verification failed");
      end
      $finish;
   end

endmodule
